FILE: hdl/sccr_pkg.sv
// sccr_pkg: shared types and constants of the sector cache clock replacement engine.
// Used by sccr_cell, sccr_ctrl and sector_cache_clock_replacement_top.
`timescale 1ns / 1ps
package sccr_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int SECTOR_W       = 32;
	localparam int SLOT_W         = 6;
	localparam int OP_W           = 2;

	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

	// broadcast command from the controller to every cell
	typedef struct packed {
		logic                latch_match;
		logic                hit_upd;
		logic                is_write;
		logic                use_scan;
		logic                hand_adv;
		logic                scan_inject;
		logic                clr_ref;
		logic                clr_dirty;
		logic                install;
		logic [SECTOR_W-1:0] sector;
	} cell_ctrl_t;

	// status of one cell; all but match are zero unless the cell is selected
	typedef struct packed {
		logic                match;
		logic                valid;
		logic                refd;
		logic                dirty;
		logic [SECTOR_W-1:0] tag;
	} cell_stat_t;

	// status of the selected cell, reduced over the row
	typedef struct packed {
		logic                any_match;
		logic                valid;
		logic                refd;
		logic                dirty;
		logic [SECTOR_W-1:0] tag;
	} look_t;

endpackage

FILE: hdl/sccr_cell.sv
// sccr_cell: one cache slot (tag, valid, reference, dirty) with its share of the
// clock hand token and the flush scan token. Depends on sccr_pkg.
`timescale 1ns / 1ps
module sccr_cell import sccr_pkg::*; #(
	parameter bit HAND_INIT = 1'b0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       hand_i,
	input  logic       scan_i,
	output logic       hand_o,
	output logic       scan_o,
	output cell_stat_t stat
);

	logic                tag_valid_q;
	logic                refd_q;
	logic                dirty_q;
	logic                match_q;
	logic                hand_q;
	logic                scan_q;
	logic [SECTOR_W-1:0] tag_q;
	logic                sel;

	assign sel = ctrl.use_scan ? scan_q : hand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_valid_q <= 1'b0;
			refd_q      <= 1'b0;
			dirty_q     <= 1'b0;
			match_q     <= 1'b0;
			hand_q      <= HAND_INIT;
			scan_q      <= 1'b0;
		end else begin
			scan_q <= scan_i;
			if (ctrl.hand_adv) begin
				hand_q <= hand_i;
			end
			if (ctrl.latch_match) begin
				match_q <= tag_valid_q && (tag_q == ctrl.sector);
			end
			if (ctrl.hit_upd && match_q) begin
				refd_q <= 1'b1;
				if (ctrl.is_write) begin
					dirty_q <= 1'b1;
				end
			end
			if (sel && ctrl.clr_ref) begin
				refd_q <= 1'b0;
			end
			if (sel && ctrl.clr_dirty) begin
				dirty_q <= 1'b0;
			end
			if (sel && ctrl.install) begin
				tag_valid_q <= 1'b1;
				refd_q      <= 1'b1;
				dirty_q     <= ctrl.is_write;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && ctrl.install) begin
			tag_q <= ctrl.sector;
		end
	end

	assign hand_o     = hand_q;
	assign scan_o     = scan_q;
	assign stat.match = match_q;
	assign stat.valid = sel & tag_valid_q;
	assign stat.refd  = sel & refd_q;
	assign stat.dirty = sel & dirty_q;
	assign stat.tag   = sel ? tag_q : '0;

endmodule

FILE: hdl/sccr_ctrl.sv
// sccr_ctrl: request sequencer (lookup, clock sweep, flush scan) and result registers.
// Depends on sccr_pkg; drives the cell row of sector_cache_clock_replacement_top.
`timescale 1ns / 1ps
module sccr_ctrl import sccr_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [OP_W-1:0]     op,
	input  logic [SECTOR_W-1:0] sector,
	input  look_t               look,
	input  logic [IDX_W-1:0]    hit_idx,
	output cell_ctrl_t          ctrl,
	output logic                busy,
	output logic                valid,
	output logic [SLOT_W-1:0]   slot,
	output logic                hit,
	output logic                fill_needed,
	output logic                writeback_needed,
	output logic [SECTOR_W-1:0] writeback_sector,
	output logic                last
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOKUP = 3'd1;
	localparam logic [2:0] ST_RESOLV = 3'd2;
	localparam logic [2:0] ST_SWEEP  = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_FEND   = 3'd5;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	logic [2:0]          state_q, state_d;
	logic [OP_W-1:0]     op_q;
	logic [SECTOR_W-1:0] sector_q;
	logic [IDX_W-1:0]    hand_idx_q, scan_idx_q;
	logic                pend_q;
	logic [IDX_W-1:0]    pend_slot_q;
	logic [SECTOR_W-1:0] pend_tag_q;
	logic                valid_q, hit_q, fill_q, wb_q, last_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SECTOR_W-1:0] wbs_q;

	logic                accept;
	logic                emit, e_hit, e_fill, e_wb, e_last;
	logic [IDX_W-1:0]    e_idx;
	logic [SECTOR_W-1:0] e_wbs;
	logic [31:0]         e_idx_wide;
	logic                take;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign take   = !look.valid || !look.refd;

	always_comb begin
		state_d          = state_q;
		ctrl             = '0;
		ctrl.sector      = sector_q;
		ctrl.is_write    = (op_q == OP_WRITE);
		ctrl.scan_inject = accept && (op == OP_FLUSH);
		emit   = 1'b0;
		e_idx  = '0;
		e_hit  = 1'b0;
		e_fill = 1'b0;
		e_wb   = 1'b0;
		e_wbs  = '0;
		e_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_FLUSH) begin
						state_d = ST_SCAN;
					end else if (op == OP_READ || op == OP_WRITE) begin
						state_d = ST_LOOKUP;
					end
				end
			end
			ST_LOOKUP: begin
				ctrl.latch_match = 1'b1;
				state_d          = ST_RESOLV;
			end
			ST_RESOLV: begin
				if (look.any_match) begin
					ctrl.hit_upd = 1'b1;
					emit         = 1'b1;
					e_idx        = hit_idx;
					e_hit        = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				ctrl.clr_ref  = 1'b1;
				ctrl.hand_adv = 1'b1;
				if (take) begin
					ctrl.install = 1'b1;
					emit         = 1'b1;
					e_idx        = hand_idx_q;
					e_fill       = 1'b1;
					e_wb         = look.dirty;
					e_wbs        = look.dirty ? look.tag : '0;
					state_d      = ST_IDLE;
				end
			end
			ST_SCAN: begin
				ctrl.use_scan = 1'b1;
				if (look.dirty) begin
					ctrl.clr_dirty = 1'b1;
					if (pend_q) begin
						emit   = 1'b1;
						e_idx  = pend_slot_q;
						e_wb   = 1'b1;
						e_wbs  = pend_tag_q;
						e_last = 1'b0;
					end
				end
				if (scan_idx_q == IDX_LAST) begin
					state_d = ST_FEND;
				end
			end
			ST_FEND: begin
				emit    = 1'b1;
				e_idx   = pend_q ? pend_slot_q : '0;
				e_wb    = pend_q;
				e_wbs   = pend_q ? pend_tag_q : '0;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign e_idx_wide = 32'(e_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hand_idx_q <= '0;
			scan_idx_q <= '0;
			pend_q     <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= emit;
			if (ctrl.hand_adv) begin
				hand_idx_q <= (hand_idx_q == IDX_LAST) ? '0 : hand_idx_q + 1'b1;
			end
			if (accept) begin
				scan_idx_q <= '0;
			end else if (state_q == ST_SCAN && scan_idx_q != IDX_LAST) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (state_q == ST_SCAN && look.dirty) begin
				pend_q <= 1'b1;
			end else if (state_q == ST_FEND) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			sector_q <= sector;
		end
		if (state_q == ST_SCAN && look.dirty) begin
			pend_slot_q <= scan_idx_q;
			pend_tag_q  <= look.tag;
		end
		if (emit) begin
			slot_q <= e_idx_wide[SLOT_W-1:0];
			hit_q  <= e_hit;
			fill_q <= e_fill;
			wb_q   <= e_wb;
			wbs_q  <= e_wbs;
			last_q <= e_last;
		end
	end

	assign valid            = valid_q;
	assign slot             = slot_q;
	assign hit              = hit_q;
	assign fill_needed      = fill_q;
	assign writeback_needed = wb_q;
	assign writeback_sector = wbs_q;
	assign last             = last_q;

endmodule

FILE: hdl/sector_cache_clock_replacement_top.sv
// sector_cache_clock_replacement_top: tag and clock replacement engine of a fully
// associative write-back sector cache. Depends on sccr_pkg, sccr_cell, sccr_ctrl.
//
// Usage:
//   A request (op, sector) is taken on a rising edge with start high and busy low.
//   op read or write gives one result, flush gives one result per dirty slot in
//   ascending order (or a single empty result), op code 3 is dropped silently.
//   Each result is shown on the result ports for one cycle with valid high; last
//   marks the final result of a request. The receiver cannot stall the block.
//   A read or write first latches the tag match of every slot, then resolves it;
//   a hit's result is registered from the resolve step, and a miss sweeps the clock
//   hand over at most SLOT_COUNT + 1 slots to find an empty or unreferenced victim.
//   A flush scans one slot per cycle. busy stays high until the final result is on
//   the ports, so one request is in flight at a time; the sweep and scan over the
//   cell row set the rate.
//   Reset empties every slot and puts the clock hand on slot 0; no clearing pass
//   is needed, the block takes a request in the first cycle after reset.
`timescale 1ns / 1ps
module sector_cache_clock_replacement_top import sccr_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [OP_W-1:0]     op,
	input  logic [SECTOR_W-1:0] sector,
	output logic                busy,
	output logic                valid,
	output logic [SLOT_W-1:0]   slot,
	output logic                hit,
	output logic                fill_needed,
	output logic                writeback_needed,
	output logic [SECTOR_W-1:0] writeback_sector,
	output logic                last
);

	localparam int IDX_W = $clog2(SLOT_COUNT);

	cell_ctrl_t              ctrl;
	cell_stat_t              stat [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]   hand_vec;
	logic [SLOT_COUNT-1:0]   scan_vec;
	look_t                   look;
	logic [IDX_W-1:0]        hit_idx;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		sccr_cell #(
			.HAND_INIT(i == 0)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.hand_i (hand_vec[(i + SLOT_COUNT - 1) % SLOT_COUNT]),
			.scan_i ((i == 0) ? ctrl.scan_inject : scan_vec[(i + SLOT_COUNT - 1) % SLOT_COUNT]),
			.hand_o (hand_vec[i]),
			.scan_o (scan_vec[i]),
			.stat   (stat[i])
		);
	end

	always_comb begin
		look    = '0;
		hit_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			look.any_match = look.any_match | stat[i].match;
			look.valid     = look.valid | stat[i].valid;
			look.refd      = look.refd | stat[i].refd;
			look.dirty     = look.dirty | stat[i].dirty;
			look.tag       = look.tag | stat[i].tag;
			if (stat[i].match) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	sccr_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.op               (op),
		.sector           (sector),
		.look             (look),
		.hit_idx          (hit_idx),
		.ctrl             (ctrl),
		.busy             (busy),
		.valid            (valid),
		.slot             (slot),
		.hit              (hit),
		.fill_needed      (fill_needed),
		.writeback_needed (writeback_needed),
		.writeback_sector (writeback_sector),
		.last             (last)
	);

	a_hand_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(hand_vec))
		else $error("clock hand token lost or duplicated");

	a_scan_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(scan_vec))
		else $error("more than one flush scan token");

	a_result_in_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result without a request in flight");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && hit) |-> (!fill_needed && !writeback_needed))
		else $error("hit result asks for fill or write-back");

endmodule

FILE: sim/sector_cache_clock_replacement_top_tb.sv
// sector_cache_clock_replacement_top_tb: self-checking bench for the clock replacement
// sector cache engine; a shadow copy of the cache predicts every result of each request.
// Depends on sccr_pkg and sector_cache_clock_replacement_top.
`timescale 1ns / 1ps

import sccr_pkg::*;

typedef struct packed {
	logic [SLOT_W-1:0]   slot;
	logic                hit;
	logic                fill;
	logic                wb;
	logic [SECTOR_W-1:0] wb_sector;
	logic                last;
} cache_result_t;

class sector_cache_shadow;
	logic [SECTOR_W-1:0] tag [SLOT_COUNT_DEF];
	bit                  present [SLOT_COUNT_DEF];
	bit                  referenced [SLOT_COUNT_DEF];
	bit                  dirty [SLOT_COUNT_DEF];
	int                  hand;
	cache_result_t       pending_results[$];
	int                  failures;

	function new();
		for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
			tag[i] = '0;
			present[i] = 0;
			referenced[i] = 0;
			dirty[i] = 0;
		end
		hand = 0;
		failures = 0;
	endfunction

	// advance the hand until an empty or unreferenced slot turns up
	function int sweep_victim();
		int h;
		bit taken;
		h = 0;
		taken = 0;
		for (int n = 0; n <= SLOT_COUNT_DEF && !taken; n++) begin
			h = hand;
			taken = !present[h] || !referenced[h];
			referenced[h] = 0;
			hand = (h + 1) % SLOT_COUNT_DEF;
		end
		return h;
	endfunction

	function void take_request(logic [OP_W-1:0] code, logic [SECTOR_W-1:0] sec);
		int last_dirty;
		int s;
		bit found;
		cache_result_t r;
		r = '0;
		case (code)
			OP_FLUSH: begin
				last_dirty = -1;
				for (int i = 0; i < SLOT_COUNT_DEF; i++)
					if (dirty[i])
						last_dirty = i;
				if (last_dirty < 0) begin
					r.last = 1'b1;
					pending_results.push_back(r);
				end else begin
					for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
						if (dirty[i]) begin
							r.slot = i[SLOT_W-1:0];
							r.wb = 1'b1;
							r.wb_sector = tag[i];
							r.last = (i == last_dirty);
							dirty[i] = 0;
							pending_results.push_back(r);
						end
					end
				end
			end
			OP_READ, OP_WRITE: begin
				found = 0;
				s = 0;
				for (int i = 0; i < SLOT_COUNT_DEF; i++)
					if (present[i] && tag[i] == sec) begin
						s = i;
						found = 1;
					end
				if (!found) begin
					s = sweep_victim();
					if (dirty[s]) begin
						r.wb = 1'b1;
						r.wb_sector = tag[s];
						dirty[s] = 0;
					end
					tag[s] = sec;
					present[s] = 1;
				end
				referenced[s] = 1;
				if (code == OP_WRITE)
					dirty[s] = 1;
				r.slot = s[SLOT_W-1:0];
				r.hit = found;
				r.fill = !found;
				r.last = 1'b1;
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function void match_result(cache_result_t got);
		cache_result_t want;
		if (pending_results.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("%0t: extra slot=%0d hit=%0b fill=%0b wb=%0b wbs=%h last=%0b",
					$time, got.slot, got.hit, got.fill, got.wb, got.wb_sector, got.last);
			return;
		end
		want = pending_results.pop_front();
		if (got.slot !== want.slot || got.hit !== want.hit || got.fill !== want.fill ||
				got.wb !== want.wb || got.wb_sector !== want.wb_sector ||
				got.last !== want.last) begin
			failures++;
			if (failures <= 10) begin
				$display("%0t: expected slot=%0d hit=%0b fill=%0b wb=%0b wbs=%h last=%0b",
					$time, want.slot, want.hit, want.fill, want.wb, want.wb_sector, want.last);
				$display("%0t: actual   slot=%0d hit=%0b fill=%0b wb=%0b wbs=%h last=%0b",
					$time, got.slot, got.hit, got.fill, got.wb, got.wb_sector, got.last);
			end
		end
	endfunction
endclass

module sector_cache_clock_replacement_top_tb;

	localparam int QUIET_LIMIT = 3000;
	localparam int POOL_SIZE   = 72;
	localparam int RANDOM_REQS = 300;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic [OP_W-1:0]     op;
	logic [SECTOR_W-1:0] sector;
	logic                busy;
	logic                valid;
	logic [SLOT_W-1:0]   slot;
	logic                hit;
	logic                fill_needed;
	logic                writeback_needed;
	logic [SECTOR_W-1:0] writeback_sector;
	logic                last;

	sector_cache_shadow  cache = new();
	logic [SECTOR_W-1:0] sector_pool [POOL_SIZE];
	int                  quiet_cycles;

	sector_cache_clock_replacement_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.op               (op),
		.sector           (sector),
		.busy             (busy),
		.valid            (valid),
		.slot             (slot),
		.hit              (hit),
		.fill_needed      (fill_needed),
		.writeback_needed (writeback_needed),
		.writeback_sector (writeback_sector),
		.last             (last)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && valid)
			cache.match_result({slot, hit, fill_needed, writeback_needed, writeback_sector, last});
	end

	always @(posedge clk) begin
		if ((start && !busy) || valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// call at a falling edge; returns at the falling edge after the request is taken
	task automatic issue_request(logic [OP_W-1:0] code, logic [SECTOR_W-1:0] sec);
		start <= 1'b1;
		op <= code;
		sector <= sec;
		do
			@(posedge clk);
		while (busy);
		cache.take_request(code, sec);
		@(negedge clk);
	endtask

	task automatic hold_off(int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	initial begin
		int burst_left;
		int pick;
		logic [OP_W-1:0] code;
		logic [SECTOR_W-1:0] sec;

		start = 1'b0;
		op = OP_READ;
		sector = '0;
		arst_n = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			sector_pool[i] = $urandom;
		sector_pool[0] = '0;
		sector_pool[1] = '1;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty flush, tag zero on an empty cache, extremes, hits, dirty flush
		issue_request(OP_FLUSH, 32'hDEAD_BEEF);
		issue_request(OP_READ, 32'h0000_0000);
		issue_request(OP_READ, 32'h0000_0000);
		issue_request(OP_WRITE, 32'hFFFF_FFFF);
		issue_request(OP_WRITE, 32'hFFFF_FFFF);
		issue_request(OP_UNUSED, 32'hAAAA_AAAA);
		issue_request(OP_WRITE, 32'h0000_0000);
		hold_off(5);
		issue_request(OP_FLUSH, 32'h0);
		issue_request(OP_FLUSH, 32'hFFFF_FFFF);
		issue_request(OP_WRITE, 32'h5555_5555);
		issue_request(OP_READ, 32'hAAAA_AAAA);
		issue_request(OP_WRITE, 32'h8000_0000);
		issue_request(OP_WRITE, 32'h0000_0001);
		issue_request(OP_READ, 32'h5555_5555);
		issue_request(OP_UNUSED, 32'h5555_5555);
		issue_request(OP_READ, 32'h1234_5678);
		issue_request(OP_WRITE, 32'hAAAA_AAAA);
		issue_request(OP_FLUSH, 32'h0);

		// random: mostly reuse of a pool a little larger than the cache, so hits,
		// full clock turns and dirty evictions all occur
		burst_left = 0;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				if ($urandom_range(0, 2) != 0)
					hold_off($urandom_range(1, 70));
			end
			burst_left--;
			pick = $urandom_range(0, 99);
			if (pick < 3)
				code = OP_UNUSED;
			else if (pick < 8)
				code = OP_FLUSH;
			else if (pick < 50)
				code = OP_READ;
			else
				code = OP_WRITE;
			if ($urandom_range(0, 9) == 0)
				sec = $urandom;
			else
				sec = sector_pool[$urandom_range(0, POOL_SIZE - 1)];
			issue_request(code, sec);
		end
		start <= 1'b0;

		while (cache.pending_results.size() != 0)
			@(posedge clk);
		repeat (SLOT_COUNT_DEF + 8) @(posedge clk);
		if (cache.failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
hdl/sccr_pkg.sv
hdl/sccr_cell.sv
hdl/sccr_ctrl.sv
hdl/sector_cache_clock_replacement_top.sv
sim/sector_cache_clock_replacement_top_tb.sv
